// ===== sv/jbfp_pkg.sv =====
// Shared types and constants for the joystick / button frame parser.
// No dependencies; design and checker files use scoped names, the testbench imports it.
`timescale 1ns / 1ps

package jbfp_pkg;

    // frame delimiters
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // joystick frame checks: raw value = hi*128 + lo, valid window is offset +/- limit
    localparam int unsigned JOY_OFFSET = 200;
    localparam int unsigned JOY_LIMIT  = 100;
    localparam logic [8:0]  JOY_RAW_MIN = 9'(JOY_OFFSET - JOY_LIMIT);
    localparam logic [8:0]  JOY_RAW_MAX = 9'(JOY_OFFSET + JOY_LIMIT);
    localparam logic [6:0]  JOY_HI_MAX  = 7'd2;

    // speed = floor(v * 51 / 20) - 255, angle = floor(u * 9 / 10) - 90, v and u in 0..200
    // both divisions are done as a multiply by a rounded-up reciprocal scaled by 2^16
    localparam logic [17:0] SPEED_RECIP = 18'd167117;
    localparam logic [15:0] ANGLE_RECIP = 16'd58983;
    localparam logic [9:0]  SPEED_BIAS  = 10'd255;
    localparam logic [8:0]  ANGLE_BIAS  = 9'd90;

    // button codes
    localparam logic [6:0] CODE_MIN     = 7'd49;
    localparam logic [6:0] CODE_MAX     = 7'd67;
    localparam logic [6:0] CODE_B0_SET  = 7'h31;   // '1'
    localparam logic [6:0] CODE_B0_CLR  = 7'h32;   // '2'
    localparam logic [6:0] CODE_B1_SET  = 7'h33;   // '3'
    localparam logic [6:0] CODE_B1_CLR  = 7'h34;   // '4'
    localparam logic [6:0] CODE_B2_SET  = 7'h35;   // '5'
    localparam logic [6:0] CODE_B2_CLR  = 7'h36;   // '6'
    localparam logic [6:0] CODE_FAST    = 7'h37;   // '7'
    localparam logic [6:0] CODE_SLOW    = 7'h38;   // '8'
    localparam logic [6:0] CODE_PULSE   = 7'h39;   // '9'
    localparam logic [6:0] CODE_B5_SET  = 7'h42;   // 'B'
    localparam logic [6:0] CODE_B5_CLR  = 7'h43;   // 'C'
    localparam logic [6:0] CODE_BTN_MIN = 7'd3;    // ETX at the code slot needs code above 2

    // frame event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_JOY    = 2'd2,
        EV_REJECT = 2'd3
    } event_t;

    // one result item
    typedef struct packed {
        logic signed [8:0] speed;
        logic signed [7:0] angle;
        logic [5:0]        button_bits;
        logic              fast_mode;
        logic              momentary_pulse;
        event_t            frame_event;
    } result_t;

endpackage

// ===== sv/jbfp_joy_map.sv =====
// Joystick frame check and mapping of X to angle and Y to speed.
// Depends on jbfp_pkg; purely combinational.
`timescale 1ns / 1ps

module jbfp_joy_map (
    input  logic [6:0]        x_hi,
    input  logic [6:0]        x_lo,
    input  logic [6:0]        y_hi,
    input  logic [6:0]        y_lo,
    output logic              joy_ok,
    output logic signed [8:0] speed,
    output logic signed [7:0] angle
);

    logic [8:0]  x_raw;
    logic [8:0]  y_raw;
    logic [7:0]  x_ofs;
    logic [7:0]  y_ofs;
    logic [25:0] speed_prod;
    logic [23:0] angle_prod;
    logic [9:0]  speed_wide;
    logic [8:0]  angle_wide;

    // raw values, hi byte is known below 3 when used so 9 bits suffice
    assign x_raw = {x_hi[1:0], x_lo};
    assign y_raw = {y_hi[1:0], y_lo};

    // window check
    assign joy_ok = (x_hi <= jbfp_pkg::JOY_HI_MAX) && (y_hi <= jbfp_pkg::JOY_HI_MAX)
                 && (x_raw >= jbfp_pkg::JOY_RAW_MIN) && (x_raw <= jbfp_pkg::JOY_RAW_MAX)
                 && (y_raw >= jbfp_pkg::JOY_RAW_MIN) && (y_raw <= jbfp_pkg::JOY_RAW_MAX);

    // shift into 0..200
    assign x_ofs = 8'(x_raw - jbfp_pkg::JOY_RAW_MIN);
    assign y_ofs = 8'(y_raw - jbfp_pkg::JOY_RAW_MIN);

    // constant-divisor scaling by reciprocal multiply
    assign speed_prod = 26'(y_ofs) * 26'(jbfp_pkg::SPEED_RECIP);
    assign angle_prod = 24'(x_ofs) * 24'(jbfp_pkg::ANGLE_RECIP);

    // remove the bias
    assign speed_wide = {1'b0, speed_prod[24:16]} - jbfp_pkg::SPEED_BIAS;
    assign angle_wide = {1'b0, angle_prod[23:16]} - jbfp_pkg::ANGLE_BIAS;
    assign speed = signed'(speed_wide[8:0]);
    assign angle = signed'(angle_wide[7:0]);

endmodule

// ===== sv/jbfp_frame_fsm.sv =====
// Frame position tracking, payload byte store and latched button/joystick state.
// Depends on jbfp_pkg and jbfp_joy_map; gives the result for the byte being taken.
`timescale 1ns / 1ps

module jbfp_frame_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    output jbfp_pkg::result_t    result
);

    typedef enum logic [2:0] {
        POS_IDLE = 3'd0,
        POS_1    = 3'd1,
        POS_2    = 3'd2,
        POS_3    = 3'd3,
        POS_4    = 3'd4,
        POS_5    = 3'd5
    } pos_t;

    pos_t              pos_reg, pos_next;
    logic [6:0]        bytes_reg [4];
    logic [5:0]        button_reg, button_next;
    logic              fast_reg, fast_next;
    logic signed [8:0] speed_reg, speed_next;
    logic signed [7:0] angle_reg, angle_next;
    logic              store_en;
    logic [1:0]        store_idx;
    logic              pulse;
    jbfp_pkg::event_t  ev;
    logic              joy_ok;
    logic signed [8:0] joy_speed;
    logic signed [7:0] joy_angle;

    jbfp_joy_map u_joy_map (
        .x_hi   (bytes_reg[0]),
        .x_lo   (bytes_reg[1]),
        .y_hi   (bytes_reg[2]),
        .y_lo   (bytes_reg[3]),
        .joy_ok (joy_ok),
        .speed  (joy_speed),
        .angle  (joy_angle)
    );

    // per-byte decision
    always_comb
    begin
        pos_next    = pos_reg;
        button_next = button_reg;
        fast_next   = fast_reg;
        speed_next  = speed_reg;
        angle_next  = angle_reg;
        store_en    = 1'b0;
        store_idx   = 2'(pos_reg - 3'd1);
        pulse       = 1'b0;
        ev          = jbfp_pkg::EV_NONE;
        unique case (pos_reg)
            POS_IDLE:
            begin
                pos_next = (rx_byte == jbfp_pkg::STX_BYTE) ? POS_1 : POS_IDLE;
            end
            POS_1, POS_2, POS_3, POS_4, POS_5:
            begin
                if (rx_byte[7])
                begin
                    // non-ascii byte aborts the frame
                    ev       = jbfp_pkg::EV_REJECT;
                    pos_next = POS_IDLE;
                end
                else if (pos_reg == POS_5)
                begin
                    // end of joystick frame
                    pos_next = POS_IDLE;
                    if (rx_byte == jbfp_pkg::ETX_BYTE && joy_ok)
                    begin
                        ev         = jbfp_pkg::EV_JOY;
                        speed_next = joy_speed;
                        angle_next = joy_angle;
                    end
                    else
                    begin
                        ev = jbfp_pkg::EV_REJECT;
                    end
                end
                else if (pos_reg == POS_2 && rx_byte == jbfp_pkg::ETX_BYTE
                         && bytes_reg[0] >= jbfp_pkg::CODE_BTN_MIN)
                begin
                    // end of button frame
                    pos_next = POS_IDLE;
                    if (bytes_reg[0] >= jbfp_pkg::CODE_MIN && bytes_reg[0] <= jbfp_pkg::CODE_MAX)
                    begin
                        ev = jbfp_pkg::EV_BUTTON;
                        case (bytes_reg[0])
                            jbfp_pkg::CODE_B0_SET: button_next[0] = 1'b1;
                            jbfp_pkg::CODE_B0_CLR: button_next[0] = 1'b0;
                            jbfp_pkg::CODE_B1_SET: button_next[1] = 1'b1;
                            jbfp_pkg::CODE_B1_CLR: button_next[1] = 1'b0;
                            jbfp_pkg::CODE_B2_SET: button_next[2] = 1'b1;
                            jbfp_pkg::CODE_B2_CLR: button_next[2] = 1'b0;
                            jbfp_pkg::CODE_FAST:
                            begin
                                button_next[3] = 1'b1;
                                fast_next      = 1'b1;
                            end
                            jbfp_pkg::CODE_SLOW:
                            begin
                                button_next[3] = 1'b0;
                                fast_next      = 1'b0;
                            end
                            jbfp_pkg::CODE_PULSE:  pulse          = 1'b1;
                            jbfp_pkg::CODE_B5_SET: button_next[5] = 1'b1;
                            jbfp_pkg::CODE_B5_CLR: button_next[5] = 1'b0;
                            default:               ;
                        endcase
                    end
                    else
                    begin
                        ev = jbfp_pkg::EV_REJECT;
                    end
                end
                else
                begin
                    // ordinary payload byte
                    store_en = 1'b1;
                    pos_next = pos_t'(pos_reg + 3'd1);
                end
            end
            default:
            begin
                pos_next = (rx_byte == jbfp_pkg::STX_BYTE) ? POS_1 : POS_IDLE;
            end
        endcase
    end

    // state and latched values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_IDLE;
            button_reg <= '0;
            fast_reg   <= 1'b0;
            speed_reg  <= '0;
            angle_reg  <= '0;
        end
        else if (take)
        begin
            pos_reg    <= pos_next;
            button_reg <= button_next;
            fast_reg   <= fast_next;
            speed_reg  <= speed_next;
            angle_reg  <= angle_next;
        end
    end

    // payload byte store, always written before it is read
    always_ff @(posedge clk)
    begin
        if (take && store_en)
        begin
            bytes_reg[store_idx] <= rx_byte[6:0];
        end
    end

    assign result.speed           = speed_next;
    assign result.angle           = angle_next;
    assign result.button_bits     = button_next;
    assign result.fast_mode       = fast_next;
    assign result.momentary_pulse = pulse;
    assign result.frame_event     = ev;

endmodule

// ===== sv/joystick_button_frame_parser_core.sv =====
// Top level of the joystick / button frame parser: handshake and result register.
// Depends on jbfp_pkg and jbfp_frame_fsm.
//
// Usage:
//   Input channel in_valid / in_ready / rx_byte carries one received serial byte per item.
//   Output channel out_valid / out_ready carries exactly one result item per input item:
//   speed, angle, button_bits, fast_mode (all values after the byte), momentary_pulse
//   (high on the item that completes a '9' button frame) and frame_event.
//   Latency: the result of a byte is on the outputs the cycle after it is accepted.
//   Throughput: one byte per cycle while the receiver takes every result; the decision for a
//   byte is a single pass of logic from the frame state to the result register.
//   When the receiver stalls, the result register holds its item and in_ready stays
//   high only if that item is being taken in the same cycle, so nothing is lost.
//   Reset (rst_n low, asynchronous) returns the frame tracker to idle, clears the
//   button latch, selects slow mode, zeroes speed and angle and empties the result
//   register. No clearing pass is needed; the block takes bytes right after reset.
//   Frames: STX, code, ETX for buttons; STX, xh, xl, yh, yl, ETX for the joystick.
`timescale 1ns / 1ps

module joystick_button_frame_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [8:0] speed,
    output logic signed [7:0] angle,
    output logic [5:0]        button_bits,
    output logic              fast_mode,
    output logic              momentary_pulse,
    output logic [1:0]        frame_event
);

    logic              take;
    logic              out_valid_reg, out_valid_next;
    jbfp_pkg::result_t result;
    jbfp_pkg::result_t result_reg;

    // a new item fits when the result register is empty or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    jbfp_frame_fsm u_frame_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .result  (result)
    );

    // output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                result_reg <= result;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign speed           = result_reg.speed;
    assign angle           = result_reg.angle;
    assign button_bits     = result_reg.button_bits;
    assign fast_mode       = result_reg.fast_mode;
    assign momentary_pulse = result_reg.momentary_pulse;
    assign frame_event     = result_reg.frame_event;

endmodule

// ===== sv/jbfp_checker.sv =====
// Port-level checks for the joystick / button frame parser, bound to the top level.
// Depends on jbfp_pkg and joystick_button_frame_parser_core.
`timescale 1ns / 1ps

module jbfp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [8:0] speed,
    input logic signed [7:0] angle,
    input logic [5:0]        button_bits,
    input logic              fast_mode,
    input logic              momentary_pulse,
    input logic [1:0]        frame_event
);

    // a stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed) && $stable(frame_event))
        else $error("result item changed while stalled");

    // pulse only comes with an applied button frame
    a_pulse_button: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && momentary_pulse |-> frame_event == jbfp_pkg::EV_BUTTON)
        else $error("momentary pulse without button frame");

    // speed and angle move only on an applied joystick frame
    a_joy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_event != jbfp_pkg::EV_JOY
        |-> speed == $past(speed) && angle == $past(angle))
        else $error("speed or angle changed without joystick frame");

    // latches move only on an applied button frame
    a_button_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_event != jbfp_pkg::EV_BUTTON
        |-> button_bits == $past(button_bits) && fast_mode == $past(fast_mode))
        else $error("button latch changed without button frame");

    // mapped values stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed >= -9'sd255 && speed <= 9'sd255
                      && angle >= -8'sd90 && angle <= 8'sd90)
        else $error("speed or angle out of range");

endmodule

bind joystick_button_frame_parser_core jbfp_checker u_jbfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .speed           (speed),
    .angle           (angle),
    .button_bits     (button_bits),
    .fast_mode       (fast_mode),
    .momentary_pulse (momentary_pulse),
    .frame_event     (frame_event)
);

// ===== dv/joystick_button_frame_parser_core_tb.sv =====
// Self-checking testbench for joystick_button_frame_parser_core: a directed stimulus table
// followed by random frames; each item is checked against a built-in parser model or a typed row.
// Depends on jbfp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module joystick_button_frame_parser_core_tb;

    import jbfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES = 4;
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 76, 0, 13};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 76, 13};
    localparam int JOY_OFS = int'(JOY_OFFSET);
    localparam int JOY_LIM = int'(JOY_LIMIT);

    // one row of the directed table; typed rows carry a hand-written expectation
    typedef struct packed {
        logic [7:0]        rx;
        logic              typed;
        logic signed [8:0] spd;
        logic signed [7:0] ang;
        logic [5:0]        btns;
        logic              fast;
        logic              pulse;
        event_t            ev;
    } script_row_t;

    localparam int SCRIPT_ROWS = 30;

    script_row_t script [SCRIPT_ROWS] = '{
        // byte ignored while idle, right after reset
        '{8'hFF, 1'b1, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{STX_BYTE, 1'b1, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        // fast button frame
        '{8'h37, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{ETX_BYTE, 1'b1, 9'sd0, 8'sd0, 6'h08, 1'b1, 1'b0, EV_BUTTON},
        // joystick at X = -100, Y = +100
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h00, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h64, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h02, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h2C, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{ETX_BYTE, 1'b1, 9'sd255, -8'sd90, 6'h08, 1'b1, 1'b0, EV_JOY},
        // byte above 127 aborts a frame
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h80, 1'b1, 9'sd255, -8'sd90, 6'h08, 1'b1, 1'b0, EV_REJECT},
        // button code just above the range
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h44, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{ETX_BYTE, 1'b1, 9'sd255, -8'sd90, 6'h08, 1'b1, 1'b0, EV_REJECT},
        // STX as payload, ETX after a low code is payload, then bad Y high byte
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{ETX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h05, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h00, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{ETX_BYTE, 1'b1, 9'sd255, -8'sd90, 6'h08, 1'b1, 1'b0, EV_REJECT},
        // overlong frame
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h01, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h01, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h01, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h01, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h41, 1'b1, 9'sd255, -8'sd90, 6'h08, 1'b1, 1'b0, EV_REJECT},
        // joystick at X = +100, Y = -100
        '{STX_BYTE, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h02, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE},
        '{8'h2C, 1'b0, 9'sd0, 8'sd0, 6'h00, 1'b0, 1'b0, EV_NONE}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic signed [8:0] speed;
    logic signed [7:0] angle;
    logic [5:0]        button_bits;
    logic              fast_mode;
    logic              momentary_pulse;
    logic [1:0]        frame_event;

    // parser model state
    logic [2:0]        trk_pos;
    logic [6:0]        trk_payload [4];
    logic [5:0]        trk_buttons;
    logic              trk_fast;
    logic signed [8:0] trk_speed;
    logic signed [7:0] trk_angle;

    result_t pending_results [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    joystick_button_frame_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .speed           (speed),
        .angle           (angle),
        .button_bits     (button_bits),
        .fast_mode       (fast_mode),
        .momentary_pulse (momentary_pulse),
        .frame_event     (frame_event)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // advance the parser model by one byte and return the item it should produce
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t    r;
        event_t     ev;
        logic       pulse;
        logic [6:0] code;
        int         jx;
        int         jy;
        ev = EV_NONE;
        pulse = 1'b0;
        code = trk_payload[0];
        if (trk_pos == 3'd0 || trk_pos > 3'd5)
        begin
            trk_pos = (b == STX_BYTE) ? 3'd1 : 3'd0;
        end
        else if (b[7])
        begin
            ev = EV_REJECT;
            trk_pos = 3'd0;
        end
        else if (trk_pos == 3'd5)
        begin
            ev = EV_REJECT;
            if (b == ETX_BYTE && trk_payload[0] <= JOY_HI_MAX && trk_payload[2] <= JOY_HI_MAX)
            begin
                jx = int'(trk_payload[0]) * 128 + int'(trk_payload[1]) - JOY_OFS;
                jy = int'(trk_payload[2]) * 128 + int'(trk_payload[3]) - JOY_OFS;
                if (jx >= -JOY_LIM && jx <= JOY_LIM && jy >= -JOY_LIM && jy <= JOY_LIM)
                begin
                    // dividends are never negative, so division truncates like floor
                    trk_speed = 9'((jy + JOY_LIM) * 510 / 200 - 255);
                    trk_angle = 8'((jx + JOY_LIM) * 180 / 200 - 90);
                    ev = EV_JOY;
                end
            end
            trk_pos = 3'd0;
        end
        else if (trk_pos == 3'd2 && b == ETX_BYTE && code >= CODE_BTN_MIN)
        begin
            if (code >= CODE_MIN && code <= CODE_MAX)
            begin
                ev = EV_BUTTON;
                case (code)
                    CODE_B0_SET: trk_buttons[0] = 1'b1;
                    CODE_B0_CLR: trk_buttons[0] = 1'b0;
                    CODE_B1_SET: trk_buttons[1] = 1'b1;
                    CODE_B1_CLR: trk_buttons[1] = 1'b0;
                    CODE_B2_SET: trk_buttons[2] = 1'b1;
                    CODE_B2_CLR: trk_buttons[2] = 1'b0;
                    CODE_FAST:
                    begin
                        trk_buttons[3] = 1'b1;
                        trk_fast = 1'b1;
                    end
                    CODE_SLOW:
                    begin
                        trk_buttons[3] = 1'b0;
                        trk_fast = 1'b0;
                    end
                    CODE_PULSE:  pulse = 1'b1;
                    CODE_B5_SET: trk_buttons[5] = 1'b1;
                    CODE_B5_CLR: trk_buttons[5] = 1'b0;
                    default: ;
                endcase
            end
            else
            begin
                ev = EV_REJECT;
            end
            trk_pos = 3'd0;
        end
        else
        begin
            trk_payload[2'(trk_pos - 3'd1)] = b[6:0];
            trk_pos = trk_pos + 3'd1;
        end
        r.speed = trk_speed;
        r.angle = trk_angle;
        r.button_bits = trk_buttons;
        r.fast_mode = trk_fast;
        r.momentary_pulse = pulse;
        r.frame_event = ev;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            fail_count++;
        end
    endfunction

    // result side: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual event %0d",
                         $time, frame_event);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("speed", int'(want.speed), int'(speed));
                check_field("angle", int'(want.angle), int'(angle));
                check_field("button_bits", int'(want.button_bits), int'(button_bits));
                check_field("fast_mode", int'(want.fast_mode), int'(fast_mode));
                check_field("momentary_pulse", int'(want.momentary_pulse),
                            int'(momentary_pulse));
                check_field("frame_event", int'(want.frame_event), int'(frame_event));
            end
        end
    end

    // send one byte, starting and ending at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predicted = parse_byte(b);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // stop sending and wait until every expected item has come
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] frame [$];
        result_t    want;
        int         sent;
        int         kind;
        int         jx;
        int         jy;
        int         raw;
        int         extra;

        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        out_ready = 1'b0;
        trk_pos = 3'd0;
        trk_payload = '{7'd0, 7'd0, 7'd0, 7'd0};
        trk_buttons = 6'd0;
        trk_fast = 1'b0;
        trk_speed = 9'sd0;
        trk_angle = 8'sd0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling
        foreach (script[i])
        begin
            want = '{speed: script[i].spd, angle: script[i].ang,
                     button_bits: script[i].btns, fast_mode: script[i].fast,
                     momentary_pulse: script[i].pulse, frame_event: script[i].ev};
            send_byte(script[i].rx, script[i].typed, want);
        end
        // finish the last joystick frame with typed extremes
        want = '{speed: -9'sd255, angle: 8'sd90, button_bits: 6'h08, fast_mode: 1'b1,
                 momentary_pulse: 1'b0, frame_event: EV_JOY};
        send_byte(8'h00, 1'b0, want);
        send_byte(8'h64, 1'b0, want);
        send_byte(ETX_BYTE, 1'b1, want);
        drain_results();

        // random frames under each idling pattern
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                frame.delete();
                kind = $urandom_range(99);
                if (kind < 35)
                begin
                    // button frame, code mostly around the valid range
                    frame.push_back(STX_BYTE);
                    if ($urandom_range(9) == 0)
                        frame.push_back(8'($urandom_range(127)));
                    else
                        frame.push_back(8'($urandom_range(int'(CODE_MIN) - 1,
                                                          int'(CODE_MAX) + 1)));
                    frame.push_back(ETX_BYTE);
                end
                else if (kind < 75)
                begin
                    // joystick frame, values a little past the limits on both sides
                    jx = int'($urandom_range(210)) - 105;
                    jy = int'($urandom_range(210)) - 105;
                    frame.push_back(STX_BYTE);
                    raw = jx + JOY_OFS;
                    frame.push_back(8'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                                 : raw / 128));
                    frame.push_back(8'(raw % 128));
                    raw = jy + JOY_OFS;
                    frame.push_back(8'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                                 : raw / 128));
                    frame.push_back(8'(raw % 128));
                    // occasionally overlong
                    frame.push_back(($urandom_range(11) == 0) ? 8'($urandom_range(127))
                                                              : ETX_BYTE);
                end
                else if (kind < 88)
                begin
                    // frame cut off by a byte above 127
                    frame.push_back(STX_BYTE);
                    extra = $urandom_range(4);
                    repeat (extra) frame.push_back(8'($urandom_range(127)));
                    frame.push_back(8'($urandom_range(128, 255)));
                end
                else
                begin
                    // line noise, mostly ignored while idle
                    extra = $urandom_range(1, 3);
                    repeat (extra) frame.push_back(8'($urandom_range(255)));
                end
                foreach (frame[k])
                    send_byte(frame[k], 1'b0, '0);
                if (kind < 88)
                    sent += frame.size();
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
